/* design/group_middle_downsampler_defines.svh */
// Assertion macros shared by the group middle downsampler checker.
`ifndef GROUP_MIDDLE_DOWNSAMPLER_DEFINES_SVH
`define GROUP_MIDDLE_DOWNSAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GMD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/gmd_pkg.sv */
// Shared constants, codes and controller interface types of the group middle downsampler.
package gmd_pkg;

	localparam int COUNT_WIDTH_DEF    = 16;
	localparam int ELEMENT_WIDTH_DEF  = 64;
	localparam int CFG_DATA_WIDTH     = 16;
	localparam int CFG_INDEX_WIDTH    = 1;
	localparam int TOTAL_COUNT_RESET  = 2;
	localparam int TARGET_COUNT_RESET = 1;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOTAL_COUNT  = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET_COUNT = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_V,
		ST_DIV_G,
		ST_DIV_S,
		ST_SECOND
	} state_t;

	typedef enum logic [1:0] {
		DIV_OP_V,
		DIV_OP_G,
		DIV_OP_S
	} div_op_t;

	typedef struct packed {
		logic    accept;
		logic    div_start;
		div_op_t div_op;
		logic    load_v;
		logic    commit;
		logic    period_zero;
		logic    emit_second;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cfg_bad;
		logic derive_needed;
		logic div_done;
		logic j_zero;
		logic two_results;
		logic out_free;
	} ctrl_status_t;

endpackage

/* design/gmd_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module gmd_divider #(
	parameter int WIDTH = gmd_pkg::COUNT_WIDTH_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] divisor_q;
	logic [WIDTH:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign fits    = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else if (start) begin
			count_q <= CNT_W'(WIDTH);
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else if (busy_q) begin
			count_q <= count_q - CNT_W'(1);
			if (count_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? WIDTH'(shifted - {1'b0, divisor_q}) : shifted[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/gmd_datapath.sv */
// Datapath: configuration, run counters, captures, run-start divisions and result registers.
module gmd_datapath #(
	parameter int COUNT_WIDTH   = gmd_pkg::COUNT_WIDTH_DEF,
	parameter int ELEMENT_WIDTH = gmd_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [gmd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [gmd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	input  logic [ELEMENT_WIDTH-1:0]             element_bits,
	input  logic                                 out_stall,
	input  gmd_pkg::ctrl_cmd_t                   cmd,
	output gmd_pkg::ctrl_status_t                status,
	output logic                                 out_valid,
	output logic [ELEMENT_WIDTH-1:0]             picked_bits,
	output logic                                 last_of_burst,
	output logic                                 end_of_run,
	output logic                                 config_error
);

	localparam int CW = COUNT_WIDTH;
	localparam int DW = COUNT_WIDTH + 1;

	logic [CW-1:0] total_q;
	logic [CW-1:0] target_q;
	logic [CW-1:0] group_size_q;
	logic [CW-1:0] extra_period_q;
	logic [CW-1:0] v_q;
	logic [CW-1:0] s_q;
	logic [CW-1:0] item_index_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] period_q;
	logic [CW-1:0] emitted_q;
	logic          fresh_q;

	logic [ELEMENT_WIDTH-1:0] before_q;
	logic [ELEMENT_WIDTH-1:0] mid_q;
	logic [ELEMENT_WIDTH-1:0] second_bits_q;
	logic                     second_eor_q;

	logic                     out_valid_q;
	logic [ELEMENT_WIDTH-1:0] picked_q;
	logic                     last_q;
	logic                     eor_q;
	logic                     err_q;

	// divider hookup
	logic          div_done;
	logic [DW-1:0] div_quo;
	logic [DW-1:0] div_dividend;
	logic [DW-1:0] div_divisor;

	// per-item terms
	logic                     cfg_bad;
	logic                     last_item;
	logic [CW-1:0]            group_size_eff;
	logic [CW-1:0]            extra_period_eff;
	logic [CW-1:0]            start_idx;
	logic [CW-1:0]            remain;
	logic [CW-1:0]            len;
	logic [DW-1:0]            half;
	logic [CW-1:0]            mid;
	logic                     mid_nz;
	logic                     cap_before;
	logic                     cap_mid;
	logic                     closes;
	logic [CW-1:0]            period_inc;
	logic                     period_hit;
	logic                     extra_go;
	logic [DW-1:0]            emitted_after;
	logic                     mid_go;
	logic [DW-1:0]            emitted_next;
	logic [ELEMENT_WIDTH-1:0] before_val;
	logic [ELEMENT_WIDTH-1:0] mid_val;
	logic                     load_first;
	logic                     out_free;

	always_comb begin
		unique case (cmd.div_op)
			gmd_pkg::DIV_OP_V: begin
				div_dividend = {1'b0, total_q} + {1'b0, target_q} - DW'(1);
				div_divisor  = {1'b0, target_q};
			end
			gmd_pkg::DIV_OP_G: begin
				div_dividend = {1'b0, total_q};
				div_divisor  = div_quo;
			end
			gmd_pkg::DIV_OP_S: begin
				div_dividend = div_quo;
				div_divisor  = {1'b0, target_q} - div_quo;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
			end
		endcase
	end

	gmd_divider #(
		.WIDTH (DW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		// a fresh derivation applies to the request it was made for
		group_size_eff   = fresh_q ? v_q : group_size_q;
		extra_period_eff = fresh_q ? s_q : extra_period_q;

		cfg_bad   = (target_q == '0) || (target_q >= total_q);
		last_item = ({1'b0, item_index_q} + DW'(1)) >= {1'b0, total_q};
		start_idx = (item_index_q >= pos_q) ? item_index_q - pos_q : '0;
		remain    = (total_q > start_idx) ? total_q - start_idx : CW'(1);
		len       = (remain < group_size_eff) ? remain : group_size_eff;
		half      = ({1'b0, len} + DW'(1)) >> 1;
		mid       = CW'(half - DW'(1));
		mid_nz    = mid != '0;
		cap_before = mid_nz && (pos_q == mid - CW'(1));
		cap_mid    = pos_q == mid;
		closes     = (({1'b0, pos_q} + DW'(1)) >= {1'b0, group_size_eff}) || last_item;

		period_inc = period_q + CW'(1);
		period_hit = (extra_period_eff != '0) && (period_inc >= extra_period_eff);
		extra_go   = period_hit && mid_nz && (emitted_q < target_q);
		emitted_after = {1'b0, emitted_q} + DW'(extra_go);
		mid_go        = emitted_after < {1'b0, target_q};
		emitted_next  = emitted_after + DW'(mid_go);

		before_val = cap_before ? element_bits : before_q;
		mid_val    = cap_mid ? element_bits : mid_q;

		out_free   = !out_valid_q || !out_stall;
		load_first = cmd.accept && (cfg_bad || (closes && (extra_go || mid_go)));
	end

	assign status.cfg_bad       = cfg_bad;
	assign status.derive_needed = !fresh_q && ((item_index_q == '0) || (group_size_q == '0));
	assign status.div_done      = div_done;
	assign status.j_zero        = div_quo == {1'b0, target_q};
	assign status.two_results   = !cfg_bad && closes && extra_go && mid_go;
	assign status.out_free      = out_free;

	// configuration and run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q        <= CW'(gmd_pkg::TOTAL_COUNT_RESET);
			target_q       <= CW'(gmd_pkg::TARGET_COUNT_RESET);
			group_size_q   <= '0;
			extra_period_q <= '0;
			item_index_q   <= '0;
			pos_q          <= '0;
			period_q       <= '0;
			emitted_q      <= '0;
			fresh_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					gmd_pkg::REG_TOTAL_COUNT:  total_q  <= CW'(cfg_data);
					gmd_pkg::REG_TARGET_COUNT: target_q <= CW'(cfg_data);
					default: ;
				endcase
			end

			if (cfg_write_en || cmd.accept) begin
				fresh_q <= 1'b0;
			end else if (cmd.commit) begin
				fresh_q <= 1'b1;
			end

			if (cmd.accept) begin
				// latch derived values with the first good request
				if (!cfg_bad && fresh_q) begin
					group_size_q   <= v_q;
					extra_period_q <= s_q;
				end
				// end of run clears the run counters
				if (last_item) begin
					item_index_q <= '0;
					pos_q        <= '0;
					period_q     <= '0;
					emitted_q    <= '0;
				end else begin
					item_index_q <= item_index_q + CW'(1);
					if (!cfg_bad) begin
						if (closes) begin
							if (extra_period_eff != '0) begin
								period_q <= period_hit ? '0 : period_inc;
							end
							emitted_q <= CW'(emitted_next);
							pos_q     <= '0;
						end else begin
							pos_q <= pos_q + CW'(1);
						end
					end
				end
			end

			if (load_first || cmd.emit_second) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_v) begin
			v_q <= CW'(div_quo);
		end
		if (cmd.commit) begin
			s_q <= cmd.period_zero ? '0 : CW'(div_quo);
		end
		if (cmd.accept && !cfg_bad) begin
			if (cap_before) begin
				before_q <= element_bits;
			end
			if (cap_mid) begin
				mid_q <= element_bits;
			end
		end
		if (load_first) begin
			eor_q <= last_item;
			if (cfg_bad) begin
				picked_q <= '0;
				last_q   <= 1'b1;
				err_q    <= 1'b1;
			end else begin
				picked_q <= extra_go ? before_val : mid_val;
				last_q   <= !(extra_go && mid_go);
				err_q    <= 1'b0;
			end
			second_bits_q <= mid_val;
			second_eor_q  <= last_item;
		end else if (cmd.emit_second) begin
			picked_q <= second_bits_q;
			last_q   <= 1'b1;
			eor_q    <= second_eor_q;
			err_q    <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign picked_bits   = picked_q;
	assign last_of_burst = last_q;
	assign end_of_run    = eor_q;
	assign config_error  = err_q;

endmodule

/* design/gmd_controller.sv */
// Controller: run-start division sequence, item acceptance and second-result issue.
module gmd_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  cfg_write_en,
	input  gmd_pkg::ctrl_status_t status,
	output gmd_pkg::ctrl_cmd_t    cmd,
	output logic                  in_stall
);

	gmd_pkg::state_t state_q;
	gmd_pkg::state_t state_d;
	logic            ready;

	assign ready    = (state_q == gmd_pkg::ST_IDLE) && status.out_free &&
	                  (status.cfg_bad || !status.derive_needed);
	assign in_stall = !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gmd_pkg::ST_IDLE: begin
				if (in_valid && ready) begin
					if (status.two_results) begin
						state_d = gmd_pkg::ST_SECOND;
					end
				end else if (!cfg_write_en && !status.cfg_bad && status.derive_needed) begin
					state_d = gmd_pkg::ST_DIV_V;
				end
			end
			gmd_pkg::ST_DIV_V: begin
				if (cfg_write_en) begin
					state_d = gmd_pkg::ST_IDLE;
				end else if (status.div_done) begin
					state_d = gmd_pkg::ST_DIV_G;
				end
			end
			gmd_pkg::ST_DIV_G: begin
				if (cfg_write_en) begin
					state_d = gmd_pkg::ST_IDLE;
				end else if (status.div_done) begin
					state_d = status.j_zero ? gmd_pkg::ST_IDLE : gmd_pkg::ST_DIV_S;
				end
			end
			gmd_pkg::ST_DIV_S: begin
				if (cfg_write_en || status.div_done) begin
					state_d = gmd_pkg::ST_IDLE;
				end
			end
			gmd_pkg::ST_SECOND: begin
				if (status.out_free) begin
					state_d = gmd_pkg::ST_IDLE;
				end
			end
			default: state_d = gmd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_op = gmd_pkg::DIV_OP_V;
		unique case (state_q)
			gmd_pkg::ST_IDLE: begin
				if (in_valid && ready) begin
					cmd.accept = 1'b1;
				end else if (!cfg_write_en && !status.cfg_bad && status.derive_needed) begin
					cmd.div_start = 1'b1;
				end
			end
			gmd_pkg::ST_DIV_V: begin
				cmd.div_op = gmd_pkg::DIV_OP_G;
				if (!cfg_write_en && status.div_done) begin
					cmd.load_v    = 1'b1;
					cmd.div_start = 1'b1;
				end
			end
			gmd_pkg::ST_DIV_G: begin
				cmd.div_op = gmd_pkg::DIV_OP_S;
				if (!cfg_write_en && status.div_done) begin
					// no spare outputs: latch with a zero extra period
					if (status.j_zero) begin
						cmd.commit      = 1'b1;
						cmd.period_zero = 1'b1;
					end else begin
						cmd.div_start = 1'b1;
					end
				end
			end
			gmd_pkg::ST_DIV_S: begin
				cmd.div_op = gmd_pkg::DIV_OP_S;
				if (!cfg_write_en && status.div_done) begin
					cmd.commit = 1'b1;
				end
			end
			gmd_pkg::ST_SECOND: begin
				cmd.emit_second = status.out_free;
			end
			default: ;
		endcase
	end

endmodule

/* design/group_middle_downsampler.sv */
// Throughput: one request per cycle in a run if output is free; a two-result close stalls input.
// Latency: a result appears in the output register the cycle after its request is accepted.
// Run start: up to three (COUNT_WIDTH+1)-step divisions on the shared serial divider stall input
// (two with no spare outputs) before a run's first request.
// Reset (arst_n low): counters and derived values clear, total_count 2, target_count 1.
module group_middle_downsampler #(
	parameter int COUNT_WIDTH   = gmd_pkg::COUNT_WIDTH_DEF,
	parameter int ELEMENT_WIDTH = gmd_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [gmd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [gmd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ELEMENT_WIDTH-1:0]            element_bits,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ELEMENT_WIDTH-1:0]            picked_bits,
	output logic                                last_of_burst,
	output logic                                end_of_run,
	output logic                                config_error
);

	gmd_pkg::ctrl_cmd_t    cmd;
	gmd_pkg::ctrl_status_t status;

	gmd_controller u_controller (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.cfg_write_en (cfg_write_en),
		.status       (status),
		.cmd          (cmd),
		.in_stall     (in_stall)
	);

	gmd_datapath #(
		.COUNT_WIDTH   (COUNT_WIDTH),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.element_bits  (element_bits),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.picked_bits   (picked_bits),
		.last_of_burst (last_of_burst),
		.end_of_run    (end_of_run),
		.config_error  (config_error)
	);

endmodule

/* design/gmd_checker.sv */
// Port-level checker for the group middle downsampler, bound to the top level.
`include "group_middle_downsampler_defines.svh"

module gmd_checker #(
	parameter int ELEMENT_WIDTH = gmd_pkg::ELEMENT_WIDTH_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [ELEMENT_WIDTH-1:0] picked_bits,
	input logic                     last_of_burst,
	input logic                     end_of_run,
	input logic                     config_error
);

	// hold a stalled result
	`GMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(picked_bits), "stalled result dropped or changed")

	// an error result is a lone zero result
	`GMD_ASSERT_IMPLY(a_err_shape, out_valid && config_error,
		picked_bits == '0 && last_of_burst, "malformed error result")

	// the second result of a burst follows right after the first is taken
	`GMD_ASSERT_NEXT(a_burst_tail, out_valid && !out_stall && !last_of_burst,
		out_valid && last_of_burst && !config_error && end_of_run == $past(end_of_run),
		"burst tail missing")

	// no new request while a burst is incomplete
	`GMD_ASSERT_IMPLY(a_burst_block, out_valid && !last_of_burst, in_stall,
		"request taken inside a burst")

endmodule

bind group_middle_downsampler gmd_checker #(
	.ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_gmd_checker (.*);
